### rtl/iouta_pkg.sv
// Shared types and constants of the IoU track associator.
`default_nettype none
package iouta_pkg;

  // Item commands
  localparam logic [1:0] CMD_DETECT = 2'd0;
  localparam logic [1:0] CMD_PURGE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_STALE     = 2'd1;
  localparam logic [1:0] REG_FRIEND    = 2'd2;

  // Register reset values
  localparam logic [7:0]  THRESHOLD_RST = 8'd77;
  localparam logic [31:0] STALE_RST     = 32'd1000000;
  localparam logic [63:0] FRIEND_RST    = 64'd0;

  // Field widths fixed by the interface
  localparam int unsigned ID_BITS    = 32;
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned CLASS_BITS = 6;
  localparam int unsigned SPEED_BITS = 22;

  // Speed divider: quotient bits below the saturation point
  localparam int unsigned DIV_STEPS = SPEED_BITS - 1;
  localparam logic [DIV_STEPS-1:0] SPEED_MAX_MAG = '1;

  // Commands from controller to datapath
  typedef struct packed {
    logic scan_start;
    logic scan_rd;
    logic fetch_rd;
    logic mul;
    logic div_init;
    logic div_step;
    logic div_fin;
    logic write;
    logic purge_rd;
    logic clear;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic found;
    logic dt_zero;
    logic out_busy;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/iouta_ctrl.sv
// Controller state machine of the IoU track associator.
`default_nettype none
module iouta_ctrl #(
  parameter int unsigned MAX_TRACKS = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_acc_i,
  input  wire  [1:0]                       command_i,
  input  iouta_pkg::dp_stat_t              stat_i,
  output iouta_pkg::ctrl_cmd_t             cmd_o,
  output logic [$clog2(MAX_TRACKS)-1:0]    slot_idx_o,
  output logic                             idle_o
);

  localparam int unsigned IW = $clog2(MAX_TRACKS);
  localparam int unsigned CW = (IW > 5) ? IW : 5;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_FETCH  = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DIVI   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_FIN    = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;
  localparam logic [3:0] S_PURGE  = 4'd9;
  localparam logic [3:0] S_PDRAIN = 4'd10;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ph_q, ph_d;
  logic          last_slot;
  logic          last_step;

  assign last_slot  = (cnt_q == CW'(MAX_TRACKS - 1));
  assign last_step  = (cnt_q == CW'(iouta_pkg::DIV_STEPS - 1));
  assign slot_idx_o = cnt_q[IW-1:0];
  assign idle_o     = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ph_d    = ph_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        ph_d  = 1'b0;
        if (in_acc_i) begin
          case (command_i)
            iouta_pkg::CMD_DETECT: begin
              cmd_o.scan_start = 1'b1;
              state_d          = S_SCAN;
            end
            iouta_pkg::CMD_PURGE: state_d = S_PURGE;
            iouta_pkg::CMD_CLEAR: cmd_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      // each slot read is followed by an idle phase so the best-match loop settles
      S_SCAN: begin
        if (!ph_q) begin
          cmd_o.scan_rd = 1'b1;
          if (last_slot) begin
            state_d = S_DRAIN;
          end else begin
            ph_d = 1'b1;
          end
        end else begin
          ph_d  = 1'b0;
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = stat_i.found ? S_FETCH : S_WRITE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch_rd = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIVI;
      end
      S_DIVI: begin
        cnt_d = '0;
        if (stat_i.dt_zero) begin
          state_d = S_WRITE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_step) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.div_fin = 1'b1;
        state_d       = S_WRITE;
      end
      S_WRITE: begin
        if (!stat_i.out_busy) begin
          cmd_o.write = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_PURGE: begin
        cmd_o.purge_rd = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (last_slot) begin
          state_d = S_PDRAIN;
        end
      end
      S_PDRAIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
    end
  end

endmodule
`default_nettype wire

### rtl/iouta_dp.sv
// Datapath of the IoU track associator: track table, IoU pipeline, speed divider.
`default_nettype none
module iouta_dp #(
  parameter int unsigned MAX_TRACKS       = 16,
  parameter int unsigned COORD_BITS       = 12,
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  iouta_pkg::ctrl_cmd_t           cmd_i,
  input  wire  [$clog2(MAX_TRACKS)-1:0]  slot_idx_i,
  output iouta_pkg::dp_stat_t            stat_o,
  input  wire                            in_acc_i,
  input  wire  [31:0]                    time_stamp_i,
  input  wire  [COORD_BITS-1:0]          box_x_i,
  input  wire  [COORD_BITS-1:0]          box_y_i,
  input  wire  [COORD_BITS-1:0]          box_width_i,
  input  wire  [COORD_BITS-1:0]          box_height_i,
  input  wire  [5:0]                     class_code_i,
  input  wire  [7:0]                     thr_i,
  input  wire  [31:0]                    stale_i,
  input  wire  [63:0]                    friend_i,
  input  wire                            out_stall_i,
  output logic                           out_valid_o,
  output logic [31:0]                    track_id_o,
  output logic [COORD_BITS-1:0]          out_x_o,
  output logic [COORD_BITS-1:0]          out_y_o,
  output logic [COORD_BITS-1:0]          out_width_o,
  output logic [COORD_BITS-1:0]          out_height_o,
  output logic [5:0]                     out_class_o,
  output logic                           is_friend_o,
  output logic signed [21:0]             velocity_x_o,
  output logic signed [21:0]             velocity_y_o,
  output logic                           new_track_o,
  output logic                           not_stored_o
);

  localparam int unsigned IW = $clog2(MAX_TRACKS);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned AW = 2 * CB + 1;
  localparam int unsigned PW = 2 * CB + 2;
  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned NW = CB + TW;
  localparam int unsigned DS = iouta_pkg::DIV_STEPS;
  localparam int unsigned SB = iouta_pkg::SPEED_BITS;

  // Latched item
  logic [31:0]   now_q;
  logic [CB-1:0] det_x_q, det_y_q, det_w_q, det_h_q;
  logic [5:0]    cls_q;

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      now_q   <= time_stamp_i;
      det_x_q <= box_x_i;
      det_y_q <= box_y_i;
      det_w_q <= box_width_i;
      det_h_q <= box_height_i;
      cls_q   <= class_code_i;
    end
  end

  // Track table
  logic [31:0]         mem_id_q   [MAX_TRACKS];
  logic [4*CB-1:0]     mem_box_q  [MAX_TRACKS];
  logic                mem_fr_q   [MAX_TRACKS];
  logic [31:0]         mem_seen_q [MAX_TRACKS];
  logic signed [SB-1:0] mem_vx_q  [MAX_TRACKS];
  logic signed [SB-1:0] mem_vy_q  [MAX_TRACKS];
  logic [MAX_TRACKS-1:0] valid_q;

  logic [IW-1:0]        rd_addr;
  logic                 rd_en;
  logic [31:0]          rd_id_q;
  logic [CB-1:0]        rd_x_q, rd_y_q, rd_w_q, rd_h_q;
  logic                 rd_fr_q;
  logic [31:0]          rd_seen_q;
  logic signed [SB-1:0] rd_vx_q, rd_vy_q;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [31:0]          wr_id;
  logic                 wr_fr;
  logic signed [SB-1:0] wr_vx, wr_vy;

  logic [IW-1:0] best_q;
  logic          found_q;
  logic [IW-1:0] free_q;
  logic          free_found_q;

  assign rd_en   = cmd_i.scan_rd | cmd_i.fetch_rd | cmd_i.purge_rd;
  assign rd_addr = cmd_i.fetch_rd ? best_q : slot_idx_i;

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_id_q   <= mem_id_q[rd_addr];
      {rd_h_q, rd_w_q, rd_y_q, rd_x_q} <= mem_box_q[rd_addr];
      rd_fr_q   <= mem_fr_q[rd_addr];
      rd_seen_q <= mem_seen_q[rd_addr];
      rd_vx_q   <= mem_vx_q[rd_addr];
      rd_vy_q   <= mem_vy_q[rd_addr];
    end
    if (wr_en) begin
      mem_id_q[wr_addr]   <= wr_id;
      mem_box_q[wr_addr]  <= {det_h_q, det_w_q, det_y_q, det_x_q};
      mem_fr_q[wr_addr]   <= wr_fr;
      mem_seen_q[wr_addr] <= now_q;
      mem_vx_q[wr_addr]   <= wr_vx;
      mem_vy_q[wr_addr]   <= wr_vy;
    end
  end

  // Stage 0 tags, travel with the read data
  logic          tok0_q, ok0_q, ptok_q;
  logic [IW-1:0] a0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= 1'b0;
      ptok_q <= 1'b0;
    end else begin
      tok0_q <= cmd_i.scan_rd;
      ptok_q <= cmd_i.purge_rd;
    end
  end

  always_ff @(posedge clk_i) begin
    ok0_q <= valid_q[slot_idx_i];
    a0_q  <= slot_idx_i;
  end

  // Stage 1: overlap extents and areas
  logic [CB:0]   x1, y1, x2, y2, det_r, det_b, slot_r, slot_b, dx_c, dy_c;
  logic [CB:0]   dx1_q, dy1_q;
  logic [AW-1:0] sa1_q, da1_q;
  logic [IW-1:0] a1_q;
  logic          tok1_q, ok1_q;

  always_comb begin
    x1     = (det_x_q > rd_x_q) ? {1'b0, det_x_q} : {1'b0, rd_x_q};
    y1     = (det_y_q > rd_y_q) ? {1'b0, det_y_q} : {1'b0, rd_y_q};
    det_r  = {1'b0, det_x_q} + {1'b0, det_w_q};
    det_b  = {1'b0, det_y_q} + {1'b0, det_h_q};
    slot_r = {1'b0, rd_x_q} + {1'b0, rd_w_q};
    slot_b = {1'b0, rd_y_q} + {1'b0, rd_h_q};
    x2     = (det_r < slot_r) ? det_r : slot_r;
    y2     = (det_b < slot_b) ? det_b : slot_b;
    dx_c   = '0;
    dy_c   = '0;
    // no overlap unless both extents are positive
    if (x2 > x1 && y2 > y1) begin
      dx_c = x2 - x1;
      dy_c = y2 - y1;
    end
  end

  always_ff @(posedge clk_i) begin
    dx1_q <= dx_c;
    dy1_q <= dy_c;
    sa1_q <= AW'(rd_w_q) * AW'(rd_h_q);
    da1_q <= AW'(det_w_q) * AW'(det_h_q);
    a1_q  <= a0_q;
    ok1_q <= ok0_q;
  end

  // Stage 2: intersection and union
  logic [AW-1:0] it_c, it2_q, un2_q;
  logic [IW-1:0] a2_q;
  logic          tok2_q, ok2_q;

  assign it_c = AW'(PW'(dx1_q) * PW'(dy1_q));

  always_ff @(posedge clk_i) begin
    it2_q <= it_c;
    un2_q <= sa1_q + da1_q - it_c;
    a2_q  <= a1_q;
    ok2_q <= ok1_q;
  end

  // Stage 3: threshold test and cross products against the best so far
  logic [AW-1:0]   bi_q, bu_q;
  logic [AW+7:0]   thr_un;
  logic [2*AW-1:0] p1_q, p2_q;
  logic            qual3_q, tok3_q, ok3_q;
  logic [IW-1:0]   a3_q;
  logic [AW-1:0]   it3_q, un3_q;

  assign thr_un = (AW + 8)'(thr_i) * (AW + 8)'(un2_q);

  always_ff @(posedge clk_i) begin
    qual3_q <= {it2_q, 8'h00} > thr_un;
    p1_q    <= (2 * AW)'(it2_q) * (2 * AW)'(bu_q);
    p2_q    <= (2 * AW)'(bi_q) * (2 * AW)'(un2_q);
    it3_q   <= it2_q;
    un3_q   <= un2_q;
    a3_q    <= a2_q;
    ok3_q   <= ok2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= 1'b0;
      tok2_q <= 1'b0;
      tok3_q <= 1'b0;
    end else begin
      tok1_q <= tok0_q;
      tok2_q <= tok1_q;
      tok3_q <= tok2_q;
    end
  end

  // Stage 4: best-match update, strict compare keeps the lowest slot on ties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (tok3_q && ok3_q && qual3_q && (!found_q || p1_q > p2_q)) begin
        found_q <= 1'b1;
      end
      if (cmd_i.scan_rd && !valid_q[slot_idx_i]) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok3_q && ok3_q && qual3_q && (!found_q || p1_q > p2_q)) begin
      best_q <= a3_q;
      bi_q   <= it3_q;
      bu_q   <= un3_q;
    end
    if (cmd_i.scan_rd && !valid_q[slot_idx_i] && !free_found_q) begin
      free_q <= slot_idx_i;
    end
  end

  // Speed: magnitude times tick rate, then a restoring divide by dt
  logic [CB-1:0]  magx, magy;
  logic [NW-1:0]  nx_q, ny_q;
  logic [31:0]    dt_q;
  logic           dtz_q, negx_q, negy_q;
  logic [63:0]    nxe, nye;
  logic [31:0]    rem_x_q, rem_y_q;
  logic [DS-1:0]  lo_x_q, lo_y_q, q_x_q, q_y_q;
  logic           sat_x_q, sat_y_q;
  logic [32:0]    tx, ty;
  logic           gex, gey;
  logic [DS-1:0]  mag_x, mag_y;
  logic signed [SB-1:0] vx_q, vy_q;

  assign magx = (det_x_q >= rd_x_q) ? det_x_q - rd_x_q : rd_x_q - det_x_q;
  assign magy = (det_y_q >= rd_y_q) ? det_y_q - rd_y_q : rd_y_q - det_y_q;
  assign nxe  = 64'(nx_q);
  assign nye  = 64'(ny_q);
  assign tx   = {rem_x_q, lo_x_q[DS-1]};
  assign ty   = {rem_y_q, lo_y_q[DS-1]};
  assign gex  = tx >= {1'b0, dt_q};
  assign gey  = ty >= {1'b0, dt_q};
  assign mag_x = sat_x_q ? iouta_pkg::SPEED_MAX_MAG : q_x_q;
  assign mag_y = sat_y_q ? iouta_pkg::SPEED_MAX_MAG : q_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      nx_q   <= NW'(magx) * NW'(TICKS_PER_SECOND);
      ny_q   <= NW'(magy) * NW'(TICKS_PER_SECOND);
      dt_q   <= now_q - rd_seen_q;
      dtz_q  <= (now_q == rd_seen_q);
      negx_q <= det_x_q < rd_x_q;
      negy_q <= det_y_q < rd_y_q;
      vx_q   <= rd_vx_q;
      vy_q   <= rd_vy_q;
    end
    if (cmd_i.div_init) begin
      // quotient of 2^DS or more saturates
      sat_x_q <= (nxe >> DS) >= 64'(dt_q);
      sat_y_q <= (nye >> DS) >= 64'(dt_q);
      rem_x_q <= 32'(nxe >> DS);
      rem_y_q <= 32'(nye >> DS);
      lo_x_q  <= nxe[DS-1:0];
      lo_y_q  <= nye[DS-1:0];
      q_x_q   <= '0;
      q_y_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_x_q <= gex ? 32'(tx - {1'b0, dt_q}) : tx[31:0];
      rem_y_q <= gey ? 32'(ty - {1'b0, dt_q}) : ty[31:0];
      lo_x_q  <= {lo_x_q[DS-2:0], 1'b0};
      lo_y_q  <= {lo_y_q[DS-2:0], 1'b0};
      q_x_q   <= {q_x_q[DS-2:0], gex};
      q_y_q   <= {q_y_q[DS-2:0], gey};
    end
    if (cmd_i.div_fin) begin
      vx_q <= negx_q ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      vy_q <= negy_q ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
    end
  end

  // Id counter of the next new track
  logic [31:0] track_id_q;

  // Write-back values
  assign wr_id   = found_q ? rd_id_q : track_id_q;
  assign wr_fr   = found_q ? rd_fr_q : friend_i[cls_q];
  assign wr_vx   = found_q ? vx_q : '0;
  assign wr_vy   = found_q ? vy_q : '0;
  assign wr_addr = found_q ? best_q : free_q;
  assign wr_en   = cmd_i.write & (found_q | free_found_q);

  // Id counter and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_id_q <= '0;
      valid_q    <= '0;
    end else if (cmd_i.clear) begin
      track_id_q <= '0;
      valid_q    <= '0;
    end else begin
      if (cmd_i.write && !found_q) begin
        track_id_q <= track_id_q + 32'd1;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (ptok_q && valid_q[a0_q] && (now_q - rd_seen_q) > stale_i) begin
        valid_q[a0_q] <= 1'b0;
      end
    end
  end

  // Result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      track_id_o   <= wr_id;
      out_x_o      <= det_x_q;
      out_y_o      <= det_y_q;
      out_width_o  <= det_w_q;
      out_height_o <= det_h_q;
      out_class_o  <= cls_q;
      is_friend_o  <= wr_fr;
      velocity_x_o <= wr_vx;
      velocity_y_o <= wr_vy;
      new_track_o  <= ~found_q;
      not_stored_o <= ~found_q & ~free_found_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.pipe_busy = tok0_q | tok1_q | tok2_q | tok3_q;
  assign stat_o.found     = found_q;
  assign stat_o.dt_zero   = dtz_q;
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

endmodule
`default_nettype wire

### rtl/iou_track_associator.sv
// Top level of the IoU track associator: register port, controller, datapath.
//
//   channel  direction  handshake             beat
//   in       input      in_valid_i/in_stall_o  command, time stamp, box, class
//   out      output     out_valid_o/out_stall_i track id, box, class, flags, speed
//   cfg      input      psel/penable/pready    threshold, stale age, friend mask
//
// A detection scans the table and drains the IoU pipeline before the next beat: the
// scan follows each table read with an idle phase, since the best-match compare closes
// a loop per slot. A match adds the fetch, multiply and divider setup states, then
// DIV_STEPS steps of the bit-serial speed divider and a finish state when the time
// step is nonzero. A purge reads every slot, then drains; a clear acts from idle.
// Reset empties the table and zeroes the id counter. A stalled result does not block
// the next beat; only that beat's write-back waits for the output register.
`default_nettype none
module iou_track_associator #(
  parameter int unsigned MAX_TRACKS       = 16,
  parameter int unsigned COORD_BITS       = 12,
  parameter int unsigned TICKS_PER_SECOND = 1000000
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // configuration port
  input  wire                   psel,
  input  wire                   penable,
  input  wire                   pwrite,
  input  wire  [4:0]            paddr,
  input  wire  [63:0]           pwdata,
  output logic [63:0]           prdata,
  output logic                  pready,
  // input channel
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire  [1:0]            command_i,
  input  wire  [31:0]           time_stamp_i,
  input  wire  [COORD_BITS-1:0] box_x_i,
  input  wire  [COORD_BITS-1:0] box_y_i,
  input  wire  [COORD_BITS-1:0] box_width_i,
  input  wire  [COORD_BITS-1:0] box_height_i,
  input  wire  [5:0]            class_code_i,
  // output channel
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [31:0]           track_id_o,
  output logic [COORD_BITS-1:0] out_x_o,
  output logic [COORD_BITS-1:0] out_y_o,
  output logic [COORD_BITS-1:0] out_width_o,
  output logic [COORD_BITS-1:0] out_height_o,
  output logic [5:0]            out_class_o,
  output logic                  is_friend_o,
  output logic signed [21:0]    velocity_x_o,
  output logic signed [21:0]    velocity_y_o,
  output logic                  new_track_o,
  output logic                  not_stored_o
);

  // Configuration registers
  logic [7:0]  thr_q;
  logic [31:0] stale_q;
  logic [63:0] friend_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= iouta_pkg::THRESHOLD_RST;
      stale_q  <= iouta_pkg::STALE_RST;
      friend_q <= iouta_pkg::FRIEND_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        iouta_pkg::REG_THRESHOLD: thr_q    <= pwdata[7:0];
        iouta_pkg::REG_STALE:     stale_q  <= pwdata[31:0];
        iouta_pkg::REG_FRIEND:    friend_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      iouta_pkg::REG_THRESHOLD: prdata = {56'd0, thr_q};
      iouta_pkg::REG_STALE:     prdata = {32'd0, stale_q};
      iouta_pkg::REG_FRIEND:    prdata = friend_q;
      default:                  prdata = '0;
    endcase
  end

  // Controller and datapath
  iouta_pkg::ctrl_cmd_t          cmd;
  iouta_pkg::dp_stat_t           stat;
  logic [$clog2(MAX_TRACKS)-1:0] slot_idx;
  logic                          idle;
  logic                          in_acc;

  assign in_stall_o = ~idle;
  assign in_acc     = in_valid_i & idle;

  iouta_ctrl #(
    .MAX_TRACKS (MAX_TRACKS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .command_i  (command_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .slot_idx_o (slot_idx),
    .idle_o     (idle)
  );

  iouta_dp #(
    .MAX_TRACKS       (MAX_TRACKS),
    .COORD_BITS       (COORD_BITS),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .slot_idx_i   (slot_idx),
    .stat_o       (stat),
    .in_acc_i     (in_acc),
    .time_stamp_i (time_stamp_i),
    .box_x_i      (box_x_i),
    .box_y_i      (box_y_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .class_code_i (class_code_i),
    .thr_i        (thr_q),
    .stale_i      (stale_q),
    .friend_i     (friend_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .track_id_o   (track_id_o),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_width_o  (out_width_o),
    .out_height_o (out_height_o),
    .out_class_o  (out_class_o),
    .is_friend_o  (is_friend_o),
    .velocity_x_o (velocity_x_o),
    .velocity_y_o (velocity_y_o),
    .new_track_o  (new_track_o),
    .not_stored_o (not_stored_o)
  );

endmodule
`default_nettype wire
